>>> hdl/docf_pkg.sv
// Shared types, constants and tables for the doorway occupancy counter and fader.
package docf_pkg;

  localparam int unsigned DIST_W = 10;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned SKIP_W = 8;
  localparam int unsigned MODE_W = 2;

  localparam int unsigned FADE_STEPS = 12;
  localparam int unsigned STEP_W = $clog2(FADE_STEPS);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(255);

  localparam int unsigned TABLE_LEN = 12;
  localparam int unsigned TIDX_W = $clog2(TABLE_LEN);

  localparam logic [1:0] CODE_NONE = 2'd0;
  localparam logic [1:0] CODE_OUT = 2'd1;
  localparam logic [1:0] CODE_IN = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FADE_ON = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FADE_OFF = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OFF = 2'd3;

  localparam logic [1:0] REG_RANGE_LOW = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE = 2'd2;

  // History packed oldest entry in the lowest bits
  localparam logic [7:0] PAT_IN_A = {CODE_NONE, CODE_IN, CODE_NONE, CODE_OUT};
  localparam logic [7:0] PAT_IN_B = {CODE_NONE, CODE_IN, CODE_OUT, CODE_NONE};
  localparam logic [7:0] PAT_OUT_A = {CODE_NONE, CODE_OUT, CODE_NONE, CODE_IN};
  localparam logic [7:0] PAT_OUT_B = {CODE_NONE, CODE_OUT, CODE_IN, CODE_NONE};

  localparam logic [LEVEL_W-1:0] RAMP_UP [TABLE_LEN] =
    '{8'd5, 8'd10, 8'd20, 8'd30, 8'd50, 8'd70, 8'd110, 8'd150, 8'd200, 8'd225, 8'd250, 8'd255};
  localparam logic [LEVEL_W-1:0] RAMP_DOWN [TABLE_LEN] =
    '{8'd255, 8'd250, 8'd225, 8'd200, 8'd150, 8'd110, 8'd70, 8'd50, 8'd30, 8'd20, 8'd10, 8'd5};

  typedef struct packed {
    logic start_on;
    logic start_off;
  } fade_cmd_t;

endpackage

>>> hdl/docf_sense.sv
// Presence coding, stable-code history, pattern match, debounce and occupancy count.
module docf_sense (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [docf_pkg::DIST_W-1:0]    range_low,
  input  logic [docf_pkg::DIST_W-1:0]    range_high,
  input  logic [docf_pkg::SKIP_W-1:0]    debounce_ticks,
  input  logic [docf_pkg::DIST_W-1:0]    outer_distance,
  input  logic [docf_pkg::DIST_W-1:0]    inner_distance,
  output logic [docf_pkg::COUNT_W-1:0]   occupancy,
  output logic                           entered,
  output logic                           exited,
  output docf_pkg::fade_cmd_t            fade_cmd
);
  import docf_pkg::*;

  logic [1:0]         prev_code;
  logic [1:0]         prev_code_next;
  logic [7:0]         hist;
  logic [7:0]         hist_next;
  logic [SKIP_W-1:0]  skip;
  logic [SKIP_W-1:0]  skip_next;
  logic [COUNT_W-1:0] count;
  logic [1:0]         code;
  logic [1:0]         stable;
  logic [7:0]         shifted;
  logic               match_in;
  logic               match_out;

  always_comb begin
    code[0] = (outer_distance > range_low) && (outer_distance <= range_high);
    code[1] = (inner_distance > range_low) && (inner_distance <= range_high);
    stable = (prev_code == code) ? code : hist[7:6];
    shifted = (hist[7:6] != stable) ? {stable, hist[7:2]} : hist;
    match_in = (shifted == PAT_IN_A) || (shifted == PAT_IN_B);
    match_out = (shifted == PAT_OUT_A) || (shifted == PAT_OUT_B);

    prev_code_next = prev_code;
    hist_next = hist;
    skip_next = skip;
    occupancy = count;
    entered = 1'b0;
    exited = 1'b0;
    fade_cmd = '0;
    if (skip != '0) begin
      skip_next = skip - SKIP_W'(1);
    end else begin
      prev_code_next = code;
      hist_next = shifted;
      if (match_in) begin
        entered = 1'b1;
        fade_cmd.start_on = (count == '0);
        if (count < COUNT_MAX) begin
          occupancy = count + COUNT_W'(1);
        end
      end else if (match_out) begin
        exited = 1'b1;
        if (count != '0) begin
          occupancy = count - COUNT_W'(1);
          fade_cmd.start_off = (count == COUNT_W'(1));
        end
      end
      if (match_in || match_out) begin
        skip_next = debounce_ticks;
        hist_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_code <= CODE_NONE;
      hist <= '0;
      skip <= '0;
      count <= '0;
    end else if (step) begin
      prev_code <= prev_code_next;
      hist <= hist_next;
      skip <= skip_next;
      count <= occupancy;
    end
  end

  a_one_match: assert property (@(posedge clk) disable iff (rst)
    !(entered && exited))
    else $error("walk-in and walk-out flagged together");

  a_clear_on_match: assert property (@(posedge clk) disable iff (rst)
    step && (entered || exited) |=> hist == '0)
    else $error("history not cleared after a match");

  a_skip_quiet: assert property (@(posedge clk) disable iff (rst)
    skip != '0 |-> !entered && !exited && !fade_cmd.start_on && !fade_cmd.start_off)
    else $error("match reported while debounce active");

endmodule

>>> hdl/docf_fade.sv
// Brightness fade sequencer: light mode, fade step and held level.
module docf_fade (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  docf_pkg::fade_cmd_t            fade_cmd,
  output logic [docf_pkg::LEVEL_W-1:0]   brightness,
  output logic [docf_pkg::MODE_W-1:0]    light_mode
);
  import docf_pkg::*;

  logic [MODE_W-1:0]  mode;
  logic [STEP_W-1:0]  fstep;
  logic [STEP_W-1:0]  fstep_next;
  logic [LEVEL_W-1:0] level;
  logic [MODE_W-1:0]  mode_cur;
  logic [STEP_W-1:0]  step_cur;
  logic [TIDX_W-1:0]  idx;

  always_comb begin
    mode_cur = mode;
    step_cur = fstep;
    if (fade_cmd.start_on) begin
      mode_cur = MODE_FADE_ON;
      step_cur = '0;
    end else if (fade_cmd.start_off) begin
      mode_cur = MODE_FADE_OFF;
      step_cur = '0;
    end
    if (32'(step_cur) < TABLE_LEN) begin
      idx = TIDX_W'(step_cur);
    end else begin
      idx = TIDX_W'(TABLE_LEN - 1);
    end

    light_mode = mode_cur;
    fstep_next = step_cur;
    brightness = level;
    if (mode_cur == MODE_FADE_ON || mode_cur == MODE_FADE_OFF) begin
      brightness = (mode_cur == MODE_FADE_ON) ? RAMP_UP[idx] : RAMP_DOWN[idx];
      if (32'(step_cur) == FADE_STEPS - 1) begin
        light_mode = (mode_cur == MODE_FADE_ON) ? MODE_ON : MODE_OFF;
        fstep_next = '0;
      end else begin
        fstep_next = step_cur + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_OFF;
      fstep <= '0;
      level <= '0;
    end else if (step) begin
      mode <= light_mode;
      fstep <= fstep_next;
      level <= brightness;
    end
  end

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ON || mode == MODE_OFF) |-> fstep == '0)
    else $error("fade step nonzero outside a fade");

endmodule

>>> hdl/doorway_occupancy_counter_fader.sv
// Top level: stream ports, configuration registers, input and result registers.
// A result passes through the input register and then the result register before it is offered.
// Throughput: one item per cycle while the output is not stalled; an empty input register refills while a result waits.
// State updates in the same cycle an item moves from the input to the result register.
// Synchronous reset clears the count, history, debounce, fade state and both valid flags.
// Reset loads range_low 1, range_high 30, debounce_ticks 0; the light starts off at level 0.
module doorway_occupancy_counter_fader (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // outer_distance, inner_distance
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // occupancy, brightness, light_mode,
                                                       // entered, exited
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [docf_pkg::DIST_W-1:0]   cfg_data
);
  import docf_pkg::*;

  logic [DIST_W-1:0]  range_low;
  logic [DIST_W-1:0]  range_high;
  logic [SKIP_W-1:0]  debounce_ticks;
  logic               in_valid;
  logic [DIST_W-1:0]  outer_distance;
  logic [DIST_W-1:0]  inner_distance;
  logic               advance;
  logic               step;
  logic [COUNT_W-1:0] occupancy;
  logic               entered;
  logic               exited;
  logic [LEVEL_W-1:0] brightness;
  logic [MODE_W-1:0]  light_mode;
  fade_cmd_t          fade_cmd;
  logic [19:0]        result;

  assign cfg_ready = 1'b1;
  assign advance = !m_axis_tvalid || m_axis_tready;
  assign step = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low <= DIST_W'(1);
      range_high <= DIST_W'(30);
      debounce_ticks <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  range_low <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
        REG_DEBOUNCE:   debounce_ticks <= cfg_data[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      in_valid <= (s_axis_tvalid && s_axis_tready) || (in_valid && !advance);
      if (advance) begin
        m_axis_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      outer_distance <= s_axis_tdata[9:0];
      inner_distance <= s_axis_tdata[19:10];
    end
    if (step) begin
      result <= {exited, entered, light_mode, brightness, occupancy};
    end
  end

  assign m_axis_tdata = {4'b0, result};

  docf_sense u_sense (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .range_low      (range_low),
    .range_high     (range_high),
    .debounce_ticks (debounce_ticks),
    .outer_distance (outer_distance),
    .inner_distance (inner_distance),
    .occupancy      (occupancy),
    .entered        (entered),
    .exited         (exited),
    .fade_cmd       (fade_cmd)
  );

  docf_fade u_fade (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .fade_cmd   (fade_cmd),
    .brightness (brightness),
    .light_mode (light_mode)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the doorway occupancy counter and fader, driven by stream traffic.
`timescale 1ns / 1ps

module testbench;
  import docf_pkg::*;

  typedef struct packed {
    logic       exited;
    logic       entered;
    logic [1:0] mode;
    logic [7:0] level;
    logic [7:0] count;
  } tally_t;

  typedef struct packed {
    logic [9:0] outer;
    logic [9:0] inner;
    logic       fixed;
    tally_t     want;
  } door_row_t;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SCRIPT_LEN = 26;
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam logic [7:0] WALK_IN_A = {CODE_NONE, CODE_IN, CODE_NONE, CODE_OUT};
  localparam logic [7:0] WALK_IN_B = {CODE_NONE, CODE_IN, CODE_OUT, CODE_NONE};
  localparam logic [7:0] WALK_OUT_A = {CODE_NONE, CODE_OUT, CODE_NONE, CODE_IN};
  localparam logic [7:0] WALK_OUT_B = {CODE_NONE, CODE_OUT, CODE_IN, CODE_NONE};

  localparam logic [7:0] LIFT_LEVELS [12] =
    '{8'd5, 8'd10, 8'd20, 8'd30, 8'd50, 8'd70, 8'd110, 8'd150, 8'd200, 8'd225, 8'd250, 8'd255};
  localparam logic [7:0] DIM_LEVELS [12] =
    '{8'd255, 8'd250, 8'd225, 8'd200, 8'd150, 8'd110, 8'd70, 8'd50, 8'd30, 8'd20, 8'd10, 8'd5};

  localparam tally_t DARK = '{exited: 1'b0, entered: 1'b0, mode: MODE_OFF,
                              level: 8'd0, count: 8'd0};
  localparam tally_t UNTYPED = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_RANGE_LOW;
  logic [9:0]  cfg_data = '0;

  doorway_occupancy_counter_fader dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // outer_distance, inner_distance
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // occupancy, brightness, light_mode, entered, exited
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  logic [9:0]  cfg_lo = 10'd1;
  logic [9:0]  cfg_hi = 10'd30;
  logic [7:0]  cfg_deb = 8'd0;
  logic [1:0]  raw_prev = CODE_NONE;
  logic [1:0]  raw_now = CODE_NONE;
  logic [1:0]  door_hist [4] = '{CODE_NONE, CODE_NONE, CODE_NONE, CODE_NONE};
  logic [7:0]  skip_left = 8'd0;
  logic [7:0]  occ_count = 8'd0;
  logic [1:0]  lamp_mode = MODE_OFF;
  int unsigned fade_pos = 0;
  logic [7:0]  lamp_level = 8'd0;

  tally_t expected_tallies [$];
  int     errors = 0;
  int     live_items = 0;
  int     burst_left = 0;
  int     cycle_count = 0;
  int     rx_mode = 0;
  int     rx_left = 0;
  int     rx_stall = 0;

  logic   s_fire = 1'b0;
  logic   m_fire = 1'b0;
  logic   cfg_fire = 1'b0;
  tally_t m_word = '0;

  door_row_t script [SCRIPT_LEN] = '{
    '{10'd0,    10'd0,    1'b1, DARK},
    '{10'd1023, 10'd1023, 1'b1, DARK},
    '{10'd1,    10'd1,    1'b1, DARK},
    '{10'd31,   10'd31,   1'b1, DARK},
    '{10'd30,   10'd0,    1'b0, UNTYPED},
    '{10'd30,   10'd0,    1'b0, UNTYPED},
    '{10'd0,    10'd2,    1'b0, UNTYPED},
    '{10'd0,    10'd2,    1'b0, UNTYPED},
    '{10'd0,    10'd0,    1'b0, UNTYPED},
    '{10'd0,    10'd0,    1'b0, UNTYPED},
    '{10'd15,   10'd15,   1'b0, UNTYPED},
    '{10'd15,   10'd15,   1'b0, UNTYPED},
    '{10'd500,  10'd20,   1'b0, UNTYPED},
    '{10'd500,  10'd20,   1'b0, UNTYPED},
    '{10'd0,    10'd0,    1'b0, UNTYPED},
    '{10'd0,    10'd0,    1'b0, UNTYPED},
    '{10'd20,   10'd500,  1'b0, UNTYPED},
    '{10'd20,   10'd500,  1'b0, UNTYPED},
    '{10'd0,    10'd0,    1'b0, UNTYPED},
    '{10'd0,    10'd0,    1'b0, UNTYPED},
    '{10'd0,    10'd9,    1'b0, UNTYPED},
    '{10'd0,    10'd9,    1'b0, UNTYPED},
    '{10'd9,    10'd0,    1'b0, UNTYPED},
    '{10'd9,    10'd0,    1'b0, UNTYPED},
    '{10'd0,    10'd0,    1'b0, UNTYPED},
    '{10'd0,    10'd0,    1'b0, UNTYPED}
  };

  function automatic logic sensed(input logic [9:0] d);
    return d > cfg_lo && d <= cfg_hi;
  endfunction

  function automatic tally_t predict_tick(input logic [9:0] outer, input logic [9:0] inner);
    logic [1:0]  code;
    logic [1:0]  settled;
    logic [7:0]  hist_word;
    logic        ent;
    logic        ext;
    int unsigned idx;
    tally_t      r;
    ent = 1'b0;
    ext = 1'b0;
    if (skip_left != 0) begin
      skip_left--;
    end else begin
      live_items++;
      code = {sensed(inner), sensed(outer)};
      raw_prev = raw_now;
      raw_now = code;
      settled = (raw_prev == raw_now) ? raw_prev : door_hist[3];
      if (door_hist[3] != settled) begin
        door_hist[0] = door_hist[1];
        door_hist[1] = door_hist[2];
        door_hist[2] = door_hist[3];
        door_hist[3] = settled;
      end
      hist_word = {door_hist[3], door_hist[2], door_hist[1], door_hist[0]};
      if (hist_word == WALK_IN_A || hist_word == WALK_IN_B) begin
        ent = 1'b1;
        if (occ_count == 0) begin
          lamp_mode = MODE_FADE_ON;
          fade_pos = 0;
        end
        if (occ_count < COUNT_MAX) occ_count++;
      end else if (hist_word == WALK_OUT_A || hist_word == WALK_OUT_B) begin
        ext = 1'b1;
        if (occ_count != 0) begin
          occ_count--;
          if (occ_count == 0) begin
            lamp_mode = MODE_FADE_OFF;
            fade_pos = 0;
          end
        end
      end
      if (ent || ext) begin
        skip_left = cfg_deb;
        foreach (door_hist[k]) door_hist[k] = CODE_NONE;
      end
    end
    if (lamp_mode == MODE_FADE_ON || lamp_mode == MODE_FADE_OFF) begin
      idx = (fade_pos < TABLE_LEN) ? fade_pos : TABLE_LEN - 1;
      lamp_level = (lamp_mode == MODE_FADE_ON) ? LIFT_LEVELS[idx] : DIM_LEVELS[idx];
      if (fade_pos + 1 >= FADE_STEPS) begin
        lamp_mode = (lamp_mode == MODE_FADE_ON) ? MODE_ON : MODE_OFF;
        fade_pos = 0;
      end else begin
        fade_pos = (fade_pos + 1) & 15;
      end
    end
    r.count = occ_count;
    r.level = lamp_level;
    r.mode = lamp_mode;
    r.entered = ent;
    r.exited = ext;
    return r;
  endfunction

  function automatic logic [9:0] pick_distance(input logic hit);
    int unsigned lo;
    int unsigned hi;
    lo = cfg_lo;
    hi = cfg_hi;
    if (lo >= hi) return 10'($urandom_range(1023, 0));
    if (hit) begin
      case ($urandom_range(5, 0))
        0: return 10'(lo + 1);
        1: return 10'(hi);
        default: return 10'($urandom_range(hi, lo + 1));
      endcase
    end
    if (hi == 1023 || $urandom_range(1, 0) == 0) begin
      if ($urandom_range(3, 0) == 0) return 10'(lo);
      return 10'($urandom_range(lo, 0));
    end
    if ($urandom_range(3, 0) == 0) return 10'(hi + 1);
    return 10'($urandom_range(1023, hi + 1));
  endfunction

  function automatic int hold_len();
    return $urandom_range(4, 2);
  endfunction

  task automatic send_item(input logic [9:0] outer, input logic [9:0] inner,
                           input logic fixed, input tally_t want);
    int     gap;
    tally_t got;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7, 0) == 0) ? 150 : $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, inner, outer};
    do @(posedge clk); while (!s_fire);
    got = predict_tick(outer, inner);
    expected_tallies.push_back(fixed ? want : got);
  endtask

  task automatic hold_code(input logic [1:0] code, input int ticks);
    repeat (ticks) send_item(pick_distance(code[0]), pick_distance(code[1]), 1'b0, UNTYPED);
  endtask

  task automatic walk(input logic inward, input logic alt);
    logic [1:0] first;
    logic [1:0] second;
    first = inward ? CODE_OUT : CODE_IN;
    second = inward ? CODE_IN : CODE_OUT;
    hold_code(CODE_NONE, hold_len() + int'(skip_left));
    hold_code(first, hold_len());
    if (!alt) hold_code(CODE_NONE, hold_len());
    hold_code(second, hold_len());
    hold_code(CODE_NONE, hold_len());
  endtask

  task automatic run_traffic(input int n);
    int target;
    int pick;
    target = live_items + n;
    while (live_items < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 60) begin
        walk($urandom_range(99, 0) < 55, 1'($urandom_range(1, 0)));
      end else if (pick < 80) begin
        repeat ($urandom_range(6, 2)) hold_code(2'($urandom_range(3, 0)), $urandom_range(3, 1));
      end else begin
        repeat ($urandom_range(8, 1))
          send_item(10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)), 1'b0, UNTYPED);
      end
    end
  endtask

  task automatic config_phase(input logic [9:0] lo, input logic [9:0] hi,
                              input logic [7:0] deb, input logic spare);
    logic [1:0] idx [4];
    logic [9:0] val [4];
    int         n;
    int         k;
    idx = '{REG_RANGE_LOW, REG_RANGE_HIGH, REG_DEBOUNCE, REG_SPARE};
    val = '{lo, hi, {2'b0, deb}, 10'h3ff};
    n = spare ? 4 : 3;
    s_axis_tvalid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    for (k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      do @(posedge clk); while (!cfg_fire);
      case (idx[k])
        REG_RANGE_LOW:  cfg_lo = val[k];
        REG_RANGE_HIGH: cfg_hi = val[k];
        REG_DEBOUNCE:   cfg_deb = val[k][7:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    s_fire = !rst && s_axis_tvalid && s_axis_tready;
    m_fire = !rst && m_axis_tvalid && m_axis_tready;
    cfg_fire = !rst && cfg_valid && cfg_ready;
    m_word = m_axis_tdata[19:0];
  end

  always @(posedge clk) begin
    tally_t want;
    logic   ready;
    if (m_fire) begin
      if (expected_tallies.size() == 0) begin
        errors++;
        $display("%0t result with none expected: expected nothing, actual %h", $time, m_word);
      end else begin
        want = expected_tallies.pop_front();
        check_field("occupancy", want.count, m_word.count);
        check_field("brightness", want.level, m_word.level);
        check_field("light_mode", want.mode, m_word.mode);
        check_field("entered", want.entered, m_word.entered);
        check_field("exited", want.exited, m_word.exited);
      end
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(2, 0);
      rx_left = $urandom_range(60, 10);
    end
    rx_left--;
    case (rx_mode)
      0: ready = 1'b1;
      1: ready = ($urandom_range(3, 0) != 0);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          ready = 1'b0;
        end else if ($urandom_range(7, 0) == 0) begin
          rx_stall = $urandom_range(8, 1);
          ready = 1'b0;
        end else begin
          ready = 1'b1;
        end
      end
    endcase
    m_axis_tready <= ready;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int k;
    int lo;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < SCRIPT_LEN; k++)
      send_item(script[k].outer, script[k].inner, script[k].fixed, script[k].want);

    config_phase(10'd0, 10'd1023, 8'd0, 1'b1);
    run_traffic(80);
    config_phase(10'd100, 10'd600, 8'd3, 1'b0);
    run_traffic(80);
    config_phase(10'd500, 10'd500, 8'd255, 1'b0);
    run_traffic(30);
    config_phase(10'd10, 10'd1000, 8'd255, 1'b0);
    walk(1'b1, 1'b0);
    config_phase(10'd10, 10'd1000, 8'd0, 1'b0);
    walk(1'b0, 1'b1);
    walk(1'b1, 1'b1);
    lo = $urandom_range(600, 0);
    config_phase(10'(lo), 10'($urandom_range(1023, lo + 1)), 8'($urandom_range(6, 0)), 1'b0);
    run_traffic(50);
    config_phase(10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)),
                 8'($urandom_range(15, 0)), 1'b0);
    run_traffic(50);

    // walk in twice, walk out until the room is empty (at most 16 walks), then walk out once more
    config_phase(10'd1, 10'd30, 8'd0, 1'b0);
    repeat (2) walk(1'b1, 1'($urandom_range(1, 0)));
    for (k = 0; k < 16 && occ_count != 0; k++) walk(1'b0, 1'($urandom_range(1, 0)));
    walk(1'b0, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
